// File: src/greedy_box_merge_macros.svh
// Assertion macros for the box merge block.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef GREEDY_BOX_MERGE_MACROS_SVH
`define GREEDY_BOX_MERGE_MACROS_SVH

// Check a property on every rising edge, quiet while reset is held
`define GBM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define GBM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gbm_pkg.sv
// Shared types, constants and helper functions of the box merge block.
// No dependencies; used by the channel interfaces and the top level.
package gbm_pkg;

  localparam int MAX_BOXES  = 32;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int MARGIN_W   = 12;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int CMP_W      = FIELD_W + 2;
  localparam int ENTRY_W    = 4 * COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [FIELD_W-1:0]           field_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
    logic   vld;
  } box_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OUTER,
    ST_SEED,
    ST_INNER,
    ST_EMIT
  } gbm_state_t;

  // Keep the low COORD_BITS of a port field as a signed coordinate
  function automatic coord_t to_coord(field_t v);
    return coord_t'(v[COORD_BITS-1:0]);
  endfunction

  // Sign-extend a coordinate back to port width
  function automatic field_t to_field(coord_t c);
    logic signed [FIELD_W-1:0] w;
    w = FIELD_W'(c);
    return field_t'(w);
  endfunction

  // Overlap of a box with the accumulator widened by the doubled margin
  function automatic logic overlaps(box_t acc, box_t b, logic [MARGIN_W:0] m2);
    logic signed [CMP_W-1:0] ms;
    logic                    hit;
    ms  = $signed({{(CMP_W-MARGIN_W-1){1'b0}}, m2});
    hit = 1'b1;
    if (CMP_W'(b.max_x) + ms < CMP_W'(acc.min_x)) hit = 1'b0;
    if (CMP_W'(b.min_x) - ms > CMP_W'(acc.max_x)) hit = 1'b0;
    if (CMP_W'(b.max_y) + ms < CMP_W'(acc.min_y)) hit = 1'b0;
    if (CMP_W'(b.min_y) - ms > CMP_W'(acc.max_y)) hit = 1'b0;
    return hit;
  endfunction

endpackage

// File: src/gbm_if.sv
// Request channels of the box merge block: box input, merged box output
// and the margin register write. Depends on gbm_pkg.
interface gbm_in_if;
  import gbm_pkg::*;
  logic   valid;
  logic   ready;
  field_t in_min_x;
  field_t in_min_y;
  field_t in_max_x;
  field_t in_max_y;
  logic   in_valid;
  logic   in_last;
  modport source (output valid, in_min_x, in_min_y, in_max_x, in_max_y, in_valid, in_last,
                  input ready);
  modport sink   (input valid, in_min_x, in_min_y, in_max_x, in_max_y, in_valid, in_last,
                  output ready);
endinterface

interface gbm_out_if;
  import gbm_pkg::*;
  logic   valid;
  logic   ready;
  field_t out_min_x;
  field_t out_min_y;
  field_t out_max_x;
  field_t out_max_y;
  logic   out_valid;
  logic   out_last;
  logic   out_overflow;
  modport source (output valid, out_min_x, out_min_y, out_max_x, out_max_y, out_valid,
                  out_last, out_overflow, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_max_x, out_max_y, out_valid,
                  out_last, out_overflow, output ready);
endinterface

interface gbm_cfg_if;
  import gbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [MARGIN_W-1:0] merge_margin;
  modport source (output valid, merge_margin, input ready);
  modport sink   (input valid, merge_margin, output ready);
endinterface

// File: src/gbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/greedy_box_merge.sv
// Top level of the greedy box merge: box store, merge sequencer, output register.
// Depends on gbm_pkg, the channel interfaces, gbm_ram and the assertion macros.
//
// Usage:
//   in_chan  takes one box per request; in_last closes the list and starts the merge.
//            Up to MAX_BOXES boxes are kept; further boxes of the list are dropped and
//            reported through out_overflow on every merged box of that list.
//   out_chan gives one merged box per request; out_last marks the final one of a list.
//   cfg_chan writes merge_margin; it is always ready. Write it only while idle; the block does not enforce this.
// Sequence:
//   Loading stores one box per accepted request. The merge pass reads each seed box not
//   yet absorbed (ST_OUTER, then ST_SEED) and compares it with every later box in ST_INNER;
//   a skipped (already absorbed) seed is passed over in ST_OUTER, each result is loaded in
//   ST_EMIT. The pace is set by the single read port of the box store, which returns one box per cycle.
//   in_chan is not ready from the last box of a list until its final result is queued.
// Reset: synchronous, active low; the list is emptied and the margin set to zero.
//   No clearing pass is needed.
// Stall: a result waits in the output register; the sequencer carries on up to the
//   next result and then holds until the register frees.
`include "greedy_box_merge_macros.svh"

module greedy_box_merge (
  input  logic      clk,
  input  logic      rst_n,
  gbm_in_if.sink    in_chan,
  gbm_out_if.source out_chan,
  gbm_cfg_if.sink   cfg_chan
);
  import gbm_pkg::*;

  gbm_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    box_count_r, box_count_nxt;
  logic                overflow_r, overflow_nxt;
  logic [MAX_BOXES-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0]    outer_r, outer_nxt;
  logic [CNT_W-1:0]    inner_r, inner_nxt;
  logic                left_r, left_nxt;
  box_t                acc_r, acc_nxt;
  logic [MARGIN_W-1:0] margin_r;
  logic                out_vld_r, out_vld_nxt;
  box_t                out_box_r, out_box_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                in_fire;
  logic                out_fire;
  logic                store_full;
  logic                wr_en;
  box_t                wr_box;
  logic                rd_en;
  logic [CNT_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_word;
  box_t                rd_box;
  logic [CNT_W-1:0]    outer_inc;
  logic [CNT_W-1:0]    inner_inc;
  logic                emit_load;

  assign in_chan.ready  = (state_r == ST_LOAD);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid & in_chan.ready;
  assign out_fire       = out_vld_r & out_chan.ready;
  assign store_full     = (box_count_r >= CNT_W'(MAX_BOXES));
  assign outer_inc      = outer_r + CNT_W'(1);
  assign inner_inc      = inner_r + CNT_W'(1);

  // Write each accepted box into the store while there is room
  assign wr_en = in_fire & ~store_full;
  assign wr_box = '{min_x: to_coord(in_chan.in_min_x),
                    min_y: to_coord(in_chan.in_min_y),
                    max_x: to_coord(in_chan.in_max_x),
                    max_y: to_coord(in_chan.in_max_y),
                    vld:   in_chan.in_valid};

  gbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (box_count_r[IDX_W-1:0]),
    .wr_data (wr_box),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[IDX_W-1:0]),
    .rd_data (rd_word)
  );

  assign rd_box = box_t'(rd_word);

  // Hold the margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      margin_r <= cfg_chan.merge_margin;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, store reads and merge datapath
  always_comb begin
    state_nxt     = state_r;
    box_count_nxt = box_count_r;
    overflow_nxt  = overflow_r;
    taken_nxt     = taken_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    left_nxt      = left_r;
    acc_nxt       = acc_r;
    rd_en         = 1'b0;
    rd_addr       = outer_r;
    emit_load     = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (store_full) begin
            overflow_nxt = 1'b1;
          end else begin
            box_count_nxt = box_count_r + CNT_W'(1);
          end
          if (in_chan.in_last) begin
            outer_nxt = '0;
            state_nxt = ST_OUTER;
          end
        end
      end

      ST_OUTER: begin
        if (outer_r >= box_count_r) begin
          box_count_nxt = '0;
          overflow_nxt  = 1'b0;
          taken_nxt     = '0;
          state_nxt     = ST_LOAD;
        end else if (taken_r[outer_r[IDX_W-1:0]]) begin
          outer_nxt = outer_inc;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = outer_r;
          taken_nxt[outer_r[IDX_W-1:0]] = 1'b1;
          state_nxt = ST_SEED;
        end
      end

      ST_SEED: begin
        acc_nxt  = rd_box;
        left_nxt = 1'b0;
        if (outer_inc < box_count_r) begin
          rd_en     = 1'b1;
          rd_addr   = outer_inc;
          inner_nxt = outer_inc;
          state_nxt = ST_INNER;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_INNER: begin
        // Absorb the box read last cycle, or note that it stays for a later seed
        if (!taken_r[inner_r[IDX_W-1:0]]) begin
          if (overlaps(acc_r, rd_box, {margin_r, 1'b0})) begin
            taken_nxt[inner_r[IDX_W-1:0]] = 1'b1;
            if (acc_r.vld) begin
              if (rd_box.min_x < acc_r.min_x) acc_nxt.min_x = rd_box.min_x;
              if (rd_box.max_x > acc_r.max_x) acc_nxt.max_x = rd_box.max_x;
              if (rd_box.min_y < acc_r.min_y) acc_nxt.min_y = rd_box.min_y;
              if (rd_box.max_y > acc_r.max_y) acc_nxt.max_y = rd_box.max_y;
            end else begin
              acc_nxt = rd_box;
            end
          end else begin
            left_nxt = 1'b1;
          end
        end
        // Advance to the next box, streaming one read per cycle
        if (inner_inc < box_count_r) begin
          rd_en     = 1'b1;
          rd_addr   = inner_inc;
          inner_nxt = inner_inc;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_vld_r || out_chan.ready) begin
          emit_load = 1'b1;
          if (left_r) begin
            outer_nxt = outer_inc;
            state_nxt = ST_OUTER;
          end else begin
            box_count_nxt = '0;
            overflow_nxt  = 1'b0;
            taken_nxt     = '0;
            state_nxt     = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output register: drop on acceptance, load a finished accumulator
  always_comb begin
    out_vld_nxt  = out_vld_r & ~out_fire;
    out_box_nxt  = out_box_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    if (emit_load) begin
      out_vld_nxt  = 1'b1;
      out_box_nxt  = acc_r;
      out_last_nxt = ~left_r;
      out_ovf_nxt  = overflow_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= '0;
      overflow_r  <= 1'b0;
      taken_r     <= '0;
      outer_r     <= '0;
      inner_r     <= '0;
      left_r      <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      box_count_r <= box_count_nxt;
      overflow_r  <= overflow_nxt;
      taken_r     <= taken_nxt;
      outer_r     <= outer_nxt;
      inner_r     <= inner_nxt;
      left_r      <= left_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_box_r  <= out_box_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.out_min_x    = to_field(out_box_r.min_x);
  assign out_chan.out_min_y    = to_field(out_box_r.min_y);
  assign out_chan.out_max_x    = to_field(out_box_r.max_x);
  assign out_chan.out_max_y    = to_field(out_box_r.max_y);
  assign out_chan.out_valid    = out_box_r.vld;
  assign out_chan.out_last     = out_last_r;
  assign out_chan.out_overflow = out_ovf_r;

  // Checks
  `GBM_ASSERT(a_count_bound, clk, rst_n, box_count_r <= CNT_W'(MAX_BOXES), "box count past store depth")
  `GBM_ASSERT(a_inner_range, clk, rst_n, (state_r == ST_INNER) |-> (inner_r > outer_r && inner_r < box_count_r), "inner index outside the live range")
  `GBM_ASSERT(a_seed_taken, clk, rst_n, (state_r == ST_SEED) |-> taken_r[outer_r[IDX_W-1:0]], "seed box not marked taken")
  `GBM_ASSERT(a_list_cleared, clk, rst_n, (emit_load && !left_r) |=> (box_count_r == '0 && taken_r == '0 && state_r == ST_LOAD), "list not cleared after its final result")

endmodule
